// ===== hdl/ptt_pkg.sv =====
// ptt_pkg: shared types and constants for the periodic timer table
// holds command and result word layouts, slot entry layout, operation and status codes
// no dependencies
package ptt_pkg;

  localparam int PTT_DEPTH   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int RW          = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FIRED     = 3'd4,
    ST_NONE      = 3'd5
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [31:0]        now;
    logic [31:0]        period;
    logic signed [15:0] repeat_count;
    logic [15:0]        target_id;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] timer_id;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0]        last_time;
    logic [31:0]        period;
    logic signed [15:0] count;
    logic [15:0]        ident;
  } entry_t;

endpackage

// ===== hdl/periodic_timer_table.sv =====
// periodic_timer_table: table of periodic timers kept in insertion order in one slot memory
// depends on ptt_pkg and ptt_slot_ram
//
//  channel   ports                    handshake
//  command   command (cmd_t)          taken at clk edge with start high and busy low
//  result    result (res_t)           valid for one cycle while strobe high, no back-pressure
//
// add: result in the cycle after acceptance, busy stays low.
// tick, remove: one pass over the n used slots through the memory read port,
// busy for the whole pass; results come out during the pass, the final word with last set.
// reset clears the fill count and id counter at once; no clearing pass is needed.
// the receiver cannot stall, so no result is ever held back.
module periodic_timer_table #(
  parameter int TABLE_DEPTH = ptt_pkg::PTT_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ptt_pkg::cmd_t command,
  output logic          strobe,
  output ptt_pkg::res_t result
);
  import ptt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t      state;
  logic [CW-1:0] fill;
  logic [15:0] next_ident;
  kind_t       op_kind;
  logic [31:0] op_now;
  logic [15:0] op_target;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] wr_idx;
  logic        p_vld;
  logic        pend_vld;
  logic [15:0] pend_id;
  logic [RW-1:0] rep_cnt;
  logic        found;

  logic        accept;
  logic        issue;
  logic        we;
  logic [IW-1:0] waddr;
  entry_t      wdata;
  entry_t      q;
  entry_t      upd;
  entry_t      add_entry;
  logic [31:0] elapsed;
  logic        fire;
  logic signed [15:0] cnt_new;
  logic        keep;
  logic        full;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign issue  = (state == S_SCAN) && (rd_idx != fill);
  assign full   = (fill == CW'(TABLE_DEPTH));

  // per-slot update for the entry coming back from memory
  always_comb begin
    elapsed = op_now - q.last_time;
    fire    = (op_kind == KIND_TICK) && (elapsed > q.period);
    cnt_new = (fire && q.count > 16'sd0) ? q.count - 16'sd1 : q.count;
    keep    = (op_kind == KIND_TICK) ? (cnt_new != 16'sd0) : (q.ident != op_target);
    upd           = q;
    upd.last_time = fire ? op_now : q.last_time;
    upd.count     = cnt_new;
  end

  always_comb begin
    add_entry.last_time = command.now;
    add_entry.period    = command.period;
    add_entry.count     = command.repeat_count;
    add_entry.ident     = next_ident;
  end

  // compaction writes trail the reads, so a write never hits a slot still to be read
  always_comb begin
    if (state == S_SCAN) begin
      we    = p_vld && keep;
      waddr = wr_idx[IW-1:0];
      wdata = upd;
    end else begin
      we    = accept && (command.kind == KIND_ADD) && !full;
      waddr = fill[IW-1:0];
      wdata = add_entry;
    end
  end

  ptt_slot_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_idx[IW-1:0]),
    .rdata (q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      next_ident <= '0;
      strobe     <= 1'b0;
      p_vld      <= 1'b0;
      pend_vld   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (command.kind)
              KIND_TICK, KIND_REMOVE: begin
                state     <= S_SCAN;
                op_kind   <= command.kind;
                op_now    <= command.now;
                op_target <= command.target_id;
                rd_idx    <= '0;
                wr_idx    <= '0;
                p_vld     <= 1'b0;
                pend_vld  <= 1'b0;
                rep_cnt   <= '0;
                found     <= 1'b0;
              end
              KIND_ADD: begin
                strobe <= 1'b1;
                if (full) begin
                  result <= '{status: ST_FULL, timer_id: 16'd0, last: 1'b1};
                end else begin
                  result     <= '{status: ST_ADDED, timer_id: next_ident, last: 1'b1};
                  fill       <= fill + CW'(1);
                  next_ident <= next_ident + 16'd1;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          p_vld <= issue;
          if (issue) begin
            rd_idx <= rd_idx + CW'(1);
          end
          if (p_vld) begin
            if (keep) begin
              wr_idx <= wr_idx + CW'(1);
            end else begin
              found <= 1'b1;
            end
            // hold back the newest firing until we know whether it is the final word
            if (fire && rep_cnt != RW'(MAX_RESULTS)) begin
              rep_cnt  <= rep_cnt + RW'(1);
              pend_vld <= 1'b1;
              pend_id  <= q.ident;
              if (pend_vld) begin
                strobe <= 1'b1;
                result <= '{status: ST_FIRED, timer_id: pend_id, last: 1'b0};
              end
            end
          end else if (!issue) begin
            state  <= S_IDLE;
            fill   <= wr_idx;
            strobe <= 1'b1;
            if (op_kind == KIND_TICK) begin
              if (pend_vld) begin
                result <= '{status: ST_FIRED, timer_id: pend_id, last: 1'b1};
              end else begin
                result <= '{status: ST_NONE, timer_id: 16'd0, last: 1'b1};
              end
            end else begin
              result <= '{status: (found ? ST_REMOVED : ST_NOT_FOUND),
                          timer_id: 16'd0, last: 1'b1};
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/ptt_slot_ram.sv =====
// ptt_slot_ram: one write port, one read port slot memory with registered read data
// depends on ptt_pkg for the entry layout
module ptt_slot_ram #(
  parameter  int DEPTH = ptt_pkg::PTT_DEPTH,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  ptt_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output ptt_pkg::entry_t rdata
);
  import ptt_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ptt_checker.sv =====
// ptt_checker: port-level checks for the periodic timer table, bound to the top level
// depends on ptt_pkg and periodic_timer_table
module ptt_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input ptt_pkg::cmd_t command,
  input logic          strobe,
  input ptt_pkg::res_t result
);
  import ptt_pkg::*;

  // only a firing word can be followed by more words of the same item
  a_single_word_last: assert property (@(posedge clk) disable iff (rst)
    strobe && result.status != ST_FIRED |-> result.last)
    else $error("non-firing result word without last");

  // an add answers in the very next cycle
  a_add_answer: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command.kind == KIND_ADD |=>
      strobe && (result.status == ST_ADDED || result.status == ST_FULL))
    else $error("add not answered one cycle after acceptance");

  // a tick or remove always walks the table
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (command.kind == KIND_TICK || command.kind == KIND_REMOVE) |=> busy)
    else $error("tick or remove accepted without going busy");

  // a word that is not final belongs to a pass still in progress
  a_mid_pass: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> busy)
    else $error("intermediate result word outside a pass");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (.*);

// ===== sim/ptt_timer_checker.sv =====
// ptt_timer_checker: watches the command and result channels of periodic_timer_table,
// keeps its own copy of the timer table, predicts every result word and compares them
// depends on ptt_pkg
module ptt_timer_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  ptt_pkg::cmd_t command,
  input  logic          strobe,
  input  ptt_pkg::res_t result,
  output int            errors,
  output int            pending
);
  import ptt_pkg::*;

  // shadow of the timer table, valid entries packed at 0 .. fill-1
  logic [31:0]        t_stamp  [PTT_DEPTH];
  logic [31:0]        t_period [PTT_DEPTH];
  logic signed [15:0] t_left   [PTT_DEPTH];
  logic [15:0]        t_id     [PTT_DEPTH];
  int                 fill;
  logic [15:0]        id_next;

  res_t due_words[$];
  res_t oldest;
  int   err_count = 0;

  assign errors = err_count;

  function automatic res_t mk_word(status_t s, logic [15:0] id, logic fin);
    res_t w;
    w.status   = s;
    w.timer_id = id;
    w.last     = fin;
    return w;
  endfunction

  task automatic drop_timer(int at);
    for (int k = at; k + 1 < fill; k++) begin
      t_stamp[k]  = t_stamp[k + 1];
      t_period[k] = t_period[k + 1];
      t_left[k]   = t_left[k + 1];
      t_id[k]     = t_id[k + 1];
    end
    fill--;
  endtask

  task automatic apply_tick(logic [31:0] now);
    int          fired;
    int          i;
    logic [31:0] elapsed;
    fired = 0;
    for (i = 0; i < fill; i++) begin
      elapsed = now - t_stamp[i];
      if (elapsed > t_period[i]) begin
        t_stamp[i] = now;
        if (t_left[i] > 0) t_left[i] = t_left[i] - 16'sd1;
        // timers past the report limit still fire, they just go unreported
        if (fired < MAX_RESULTS) begin
          due_words = {due_words, mk_word(ST_FIRED, t_id[i], 1'b0)};
          fired++;
        end
      end
    end
    i = 0;
    while (i < fill) begin
      if (t_left[i] == 0) drop_timer(i);
      else i++;
    end
    if (fired == 0) due_words = {due_words, mk_word(ST_NONE, 16'd0, 1'b1)};
    else due_words[due_words.size() - 1].last = 1'b1;
  endtask

  task automatic apply_add(cmd_t c);
    if (fill >= PTT_DEPTH) begin
      due_words = {due_words, mk_word(ST_FULL, 16'd0, 1'b1)};
    end else begin
      t_stamp[fill]  = c.now;
      t_period[fill] = c.period;
      t_left[fill]   = c.repeat_count;
      t_id[fill]     = id_next;
      fill++;
      due_words = {due_words, mk_word(ST_ADDED, id_next, 1'b1)};
      id_next = id_next + 16'd1;
    end
  endtask

  task automatic apply_remove(logic [15:0] target);
    int i;
    bit hit;
    i   = 0;
    hit = 1'b0;
    // ids repeat after the counter wraps, so every match goes
    while (i < fill) begin
      if (t_id[i] == target) begin
        drop_timer(i);
        hit = 1'b1;
      end else begin
        i++;
      end
    end
    due_words = {due_words, mk_word(hit ? ST_REMOVED : ST_NOT_FOUND, 16'd0, 1'b1)};
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill    = 0;
      id_next = '0;
      due_words.delete();
    end else begin
      if (strobe) begin
        if (due_words.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result word: expected none, got status %0d id %0d last %0d",
                   $time, result.status, result.timer_id, result.last);
        end else begin
          oldest = due_words.pop_front();
          if (result.status !== oldest.status || result.timer_id !== oldest.timer_id ||
              result.last !== oldest.last) begin
            err_count++;
            $display("%0t: result mismatch: expected status %0d id %0d last %0d,",
                     $time, oldest.status, oldest.timer_id, oldest.last,
                     " got status %0d id %0d last %0d",
                     result.status, result.timer_id, result.last);
          end
        end
      end
      if (start && !busy) begin
        case (command.kind)
          KIND_TICK:   apply_tick(command.now);
          KIND_ADD:    apply_add(command);
          KIND_REMOVE: apply_remove(command.target_id);
          default: ;
        endcase
      end
    end
    pending <= due_words.size();
  end

endmodule

// ===== sim/tb_periodic_timer_table.sv =====
// tb_periodic_timer_table: drives directed and random command words into periodic_timer_table
// in three idle phases, and reports the verdict of ptt_timer_checker
// depends on ptt_pkg, periodic_timer_table and ptt_timer_checker
module tb_periodic_timer_table;
  import ptt_pkg::*;

  localparam int          CYCLE_LIMIT  = 5_000_000;
  localparam int          DRAIN_CYCLES = PTT_DEPTH + 8;
  localparam int          MAX_GAP      = 20;
  localparam int          POOL_SIZE    = 64;
  localparam kind_t       KIND_SPARE   = kind_t'(2'd3);
  localparam logic [31:0] NEVER_DUE    = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t command = '0;
  logic busy;
  logic strobe;
  res_t result;
  int   errors;
  int   pending;

  int          cycles = 0;
  int          idle_pct = 0;
  logic [31:0] clock_ms = '0;
  logic [15:0] added_ids[$];

  always #5 clk = ~clk;

  periodic_timer_table uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .strobe(strobe), .result(result)
  );

  ptt_timer_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .strobe(strobe), .result(result), .errors(errors), .pending(pending)
  );

  // recent ids handed out, sampled mid-cycle so the stimulus sees a settled pool
  always @(negedge clk) begin
    if (!rst && strobe && result.status == ST_ADDED) begin
      added_ids = {added_ids, result.timer_id};
      if (added_ids.size() > POOL_SIZE) void'(added_ids.pop_front());
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic cmd_t make_cmd(kind_t k, logic [31:0] now, logic [31:0] per,
                                    logic signed [15:0] rc, logic [15:0] tgt);
    cmd_t c;
    c.kind         = k;
    c.now          = now;
    c.period       = per;
    c.repeat_count = rc;
    c.target_id    = tgt;
    return c;
  endfunction

  // start stays high across back-to-back words, it is only lowered for a gap
  task automatic send(cmd_t c);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    command <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_word(output bit counted);
    cmd_t c;
    int   pick;
    int   r;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 3) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 60);
    // unused fields carry noise
    c = make_cmd(KIND_TICK, clock_ms, $urandom, 16'($urandom), 16'($urandom));
    counted = 1'b1;
    if (pick < 40) begin
      c.kind = KIND_TICK;
    end else if (pick < 75) begin
      c.kind = KIND_ADD;
      r = $urandom_range(9);
      case (r)
        0:       c.period = '0;
        1:       c.period = NEVER_DUE;
        2:       c.period = $urandom;
        default: c.period = $urandom_range(0, 120);
      endcase
      r = $urandom_range(9);
      case (r)
        0:       c.repeat_count = '0;
        1:       c.repeat_count = 16'($urandom);
        2, 3:    c.repeat_count = -16'sd1;
        default: c.repeat_count = 16'($urandom_range(1, 4));
      endcase
    end else if (pick < 97) begin
      c.kind = KIND_REMOVE;
      r = $urandom_range(9);
      if (r < 8 && added_ids.size() > 0)
        c.target_id = added_ids[$urandom_range(added_ids.size() - 1)];
    end else begin
      c.kind  = KIND_SPARE;
      counted = 1'b0;
    end
    send(c);
  endtask

  task automatic random_phase(int words, int pct);
    int done;
    bit counted;
    done     = 0;
    idle_pct = pct;
    while (done < words) begin
      random_word(counted);
      if (counted) done++;
    end
  endtask

  initial begin
    logic [31:0]        per;
    logic signed [15:0] rc;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, unused kind, fill to the brim, full, wrapped elapsed time
    idle_pct = 19;
    send(make_cmd(KIND_TICK, 32'd0, NEVER_DUE, 16'sd0, 16'd0));
    send(make_cmd(KIND_REMOVE, 32'd0, 32'd0, 16'sd0, 16'd0));
    send(make_cmd(KIND_SPARE, NEVER_DUE, NEVER_DUE, -16'sd1, 16'hFFFF));
    for (int i = 0; i < PTT_DEPTH; i++) begin
      per = 32'(i);
      rc  = (i % 2 == 1) ? -16'sd1 : 16'sd2;
      case (i)
        0: rc  = 16'sd1;
        1: per = NEVER_DUE;
        2: rc  = 16'sd0;
        3: rc  = 16'sh7FFF;
        4: rc  = 16'sh8000;
        default: ;
      endcase
      send(make_cmd(KIND_ADD, 32'hFFFF_FFF0 + 32'(i), per, rc, 16'(i)));
    end
    send(make_cmd(KIND_ADD, 32'd7, 32'd1, 16'sd1, 16'd0));
    send(make_cmd(KIND_TICK, 32'd20, 32'd0, 16'sd0, 16'd0));
    send(make_cmd(KIND_REMOVE, 32'd20, 32'd0, 16'sd0, 16'd3));
    send(make_cmd(KIND_REMOVE, 32'd20, 32'd0, 16'sd0, 16'hFFFF));
    send(make_cmd(KIND_TICK, 32'h8000_0000, 32'd0, 16'sd0, 16'd0));
    clock_ms = 32'h8000_0000;

    random_phase(130, 19);
    random_phase(130, 49);
    random_phase(140, 0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
